// ===== design/bmp_pkg.sv =====
// Package for the 24-bit BMP stream decoder: header layout, limits,
// phase and result-kind codes, and the item and result structs.
// No dependencies.
package bmp_pkg;

  // Image limits accepted by the decoder
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // Row and column counters must hold the dimension itself
  localparam int unsigned DIM_W      = $clog2(MAX_DIM + 1);

  // Fixed field widths of the result beat
  localparam int unsigned IDX_W      = 24;
  localparam int unsigned OUT_DIM_W  = 13;

  // Header layout (byte offsets, little-endian fields)
  localparam int unsigned HDR_LEN    = 54;
  localparam int unsigned HDR_POS_W  = 6;
  localparam int unsigned OFS_SIG0   = 0;
  localparam int unsigned OFS_SIG1   = 1;
  localparam int unsigned OFS_START  = 10;
  localparam int unsigned OFS_WIDTH  = 18;
  localparam int unsigned OFS_HEIGHT = 22;
  localparam int unsigned OFS_DEPTH  = 28;

  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4D;
  localparam logic [15:0] DEPTH_RGB  = 16'd24;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXELS = 3'd2,
    PH_PAD    = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_BAD_SIG   = 2'd1,
    KIND_BAD_DEPTH = 2'd2,
    KIND_BAD_SIZE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [IDX_W-1:0]       pixel_index;
    logic [OUT_DIM_W-1:0]   image_width;
    logic [OUT_DIM_W-1:0]   image_height;
    logic                   last_pixel;
  } result_t;

endpackage

// ===== design/bmp_byte_if.sv =====
// Byte channel into the BMP decoder: valid/ready plus one file byte.
// Depends on nothing.
interface bmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// ===== design/bmp_pix_if.sv =====
// Result channel out of the BMP decoder: valid/ready plus pixel or error beat.
// Depends on nothing.
interface bmp_pix_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [23:0] pixel_index;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        last_pixel;

  modport source (output valid, output kind, output red, output green, output blue,
                  output pixel_index, output image_width, output image_height,
                  output last_pixel, input ready);
  modport sink   (input valid, input kind, input red, input green, input blue,
                  input pixel_index, input image_width, input image_height,
                  input last_pixel, output ready);
endinterface

// ===== design/bmp_in_reg.sv =====
// Input register of the BMP decoder: holds one byte beat for the parser.
// Depends on bmp_pkg and bmp_byte_if.
module bmp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  bmp_byte_if.sink          byte_i,
  input  logic              take_i,
  output logic              item_valid_o,
  output bmp_pkg::in_item_t item_o
);
  import bmp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // Ready whenever the held beat is empty or leaves this cycle
  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte  <= byte_i.data_byte;
      item_q.first_byte <= byte_i.first_byte;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== design/bmp_parser.sv =====
// Parser of the BMP decoder: header capture and checks, offset skip,
// pixel assembly with row padding and flip. Depends on bmp_pkg.
module bmp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  bmp_pkg::in_item_t item_i,
  input  logic              can_take_i,
  output logic              take_o,
  output logic              res_valid_o,
  output bmp_pkg::result_t  res_o
);
  import bmp_pkg::*;

  phase_e           phase_q, phase_d, cur_phase;
  logic [31:0]      pos_q, pos_d, cur_pos;
  logic             sig_ok_q, sig_ok_d;
  logic [31:0]      width_q, width_d;
  logic [31:0]      height_q, height_d;
  logic [15:0]      depth_q, depth_d;
  logic [31:0]      start_q, start_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] col_q, col_d;
  logic [1:0]       bip_q, bip_d;
  logic [1:0]       pad_q, pad_d;
  logic [7:0]       blue_q, blue_d;
  logic [7:0]       green_q, green_d;
  logic [IDX_W-1:0] row_base_q, row_base_d;
  logic             top_down_q, top_down_d;

  // Header-derived values, settled long before the last header byte
  logic [31:0]      abs_h_q, abs_h_d;
  logic [IDX_W-1:0] base_init_q, base_init_d;

  logic [HDR_POS_W-1:0] hdr_pos;
  logic [1:0]           lane;
  logic [DIM_W-1:0]     w_dim, h_dim;
  logic                 take, do_pixel, end_row, last;
  logic                 size_bad;
  logic [7:0]           b;

  assign w_dim = width_q[DIM_W-1:0];
  assign h_dim = abs_h_q[DIM_W-1:0];
  assign b     = item_i.data_byte;

  // Absolute height and the start of the bottom row for flipped images
  assign abs_h_d     = height_q[31] ? (32'd0 - height_q) : height_q;
  assign base_init_d = IDX_W'(IDX_W'(DIM_W'(h_dim - 1'b1)) * IDX_W'(w_dim));

  assign size_bad = width_q[31] || (width_q == 32'd0) || (width_q > 32'(MAX_WIDTH)) ||
                    (abs_h_q == 32'd0) || (abs_h_q > 32'(MAX_HEIGHT)) ||
                    (start_q < 32'(HDR_LEN));

  // Next state and result for the beat in the input register
  always_comb begin
    take      = item_valid_i && can_take_i;
    cur_phase = item_i.first_byte ? PH_HEADER : phase_q;
    cur_pos   = item_i.first_byte ? 32'd0 : pos_q;
    hdr_pos   = cur_pos[HDR_POS_W-1:0];
    lane      = 2'd0;

    phase_d    = phase_q;
    sig_ok_d   = sig_ok_q;
    width_d    = width_q;
    height_d   = height_q;
    depth_d    = depth_q;
    start_d    = start_q;
    row_d      = row_q;
    col_d      = col_q;
    bip_d      = bip_q;
    pad_d      = pad_q;
    blue_d     = blue_q;
    green_d    = green_q;
    row_base_d = row_base_q;
    top_down_d = top_down_q;

    // A marked first byte restarts the parse from a clean state
    if (item_i.first_byte) begin
      phase_d    = PH_HEADER;
      sig_ok_d   = 1'b0;
      width_d    = '0;
      height_d   = '0;
      depth_d    = '0;
      start_d    = '0;
      row_d      = '0;
      col_d      = '0;
      bip_d      = '0;
      pad_d      = '0;
      blue_d     = '0;
      green_d    = '0;
      row_base_d = '0;
      top_down_d = 1'b0;
    end

    pos_d = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;

    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_PIXEL;
    do_pixel    = 1'b0;
    end_row     = 1'b0;
    last        = 1'b0;

    unique case (cur_phase)
      PH_HEADER: begin
        // Field capture, one byte lane at a time
        if (hdr_pos == HDR_POS_W'(OFS_SIG0)) begin
          sig_ok_d = (b == SIG_B);
        end else if (hdr_pos == HDR_POS_W'(OFS_SIG1)) begin
          sig_ok_d = sig_ok_q && (b == SIG_M);
        end else if (hdr_pos >= HDR_POS_W'(OFS_START) &&
                     hdr_pos <  HDR_POS_W'(OFS_START + 4)) begin
          lane = 2'(hdr_pos - HDR_POS_W'(OFS_START));
          start_d[8*lane +: 8] = b;
        end else if (hdr_pos >= HDR_POS_W'(OFS_WIDTH) &&
                     hdr_pos <  HDR_POS_W'(OFS_WIDTH + 4)) begin
          lane = 2'(hdr_pos - HDR_POS_W'(OFS_WIDTH));
          width_d[8*lane +: 8] = b;
        end else if (hdr_pos >= HDR_POS_W'(OFS_HEIGHT) &&
                     hdr_pos <  HDR_POS_W'(OFS_HEIGHT + 4)) begin
          lane = 2'(hdr_pos - HDR_POS_W'(OFS_HEIGHT));
          height_d[8*lane +: 8] = b;
        end else if (hdr_pos >= HDR_POS_W'(OFS_DEPTH) &&
                     hdr_pos <  HDR_POS_W'(OFS_DEPTH + 2)) begin
          lane = 2'(hdr_pos - HDR_POS_W'(OFS_DEPTH));
          depth_d[8*lane[0] +: 8] = b;
        end

        // Last header byte: validate, then set up the pixel walk
        if (hdr_pos == HDR_POS_W'(HDR_LEN - 1)) begin
          if (!sig_ok_q) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_SIG;
            phase_d     = PH_DONE;
          end else if (depth_q != DEPTH_RGB) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_DEPTH;
            phase_d     = PH_DONE;
          end else if (size_bad) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_SIZE;
            phase_d     = PH_DONE;
          end else begin
            top_down_d = height_q[31];
            row_d      = '0;
            col_d      = '0;
            bip_d      = '0;
            row_base_d = height_q[31] ? '0 : base_init_q;
            phase_d    = (start_q == 32'(HDR_LEN)) ? PH_PIXELS : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (cur_pos >= start_q) begin
          phase_d  = PH_PIXELS;
          do_pixel = 1'b1;
        end
      end
      PH_PIXELS: begin
        do_pixel = 1'b1;
      end
      PH_PAD: begin
        if (pad_q != 2'd0) begin
          pad_d = pad_q - 2'd1;
        end
        end_row = (pad_q <= 2'd1);
      end
      default: begin
      end
    endcase

    // Pixel bytes arrive as blue, green, red
    if (do_pixel) begin
      case (bip_q)
        2'd0: begin
          blue_d = b;
          bip_d  = 2'd1;
        end
        2'd1: begin
          green_d = b;
          bip_d   = 2'd2;
        end
        default: begin
          bip_d = 2'd0;
          last  = (row_q == DIM_W'(h_dim - 1'b1)) && (col_q == DIM_W'(w_dim - 1'b1));
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_PIXEL;
          res_o.red          = b;
          res_o.green        = green_q;
          res_o.blue         = blue_q;
          res_o.pixel_index  = row_base_q + IDX_W'(col_q);
          res_o.image_width  = width_q[OUT_DIM_W-1:0];
          res_o.image_height = abs_h_q[OUT_DIM_W-1:0];
          res_o.last_pixel   = last;
          col_d = DIM_W'(col_q + 1'b1);
          if (DIM_W'(col_q + 1'b1) == w_dim) begin
            pad_d = w_dim[1:0];
            if (w_dim[1:0] != 2'd0 && !last) begin
              phase_d = PH_PAD;
            end else begin
              end_row = 1'b1;
            end
          end
        end
      endcase
    end

    // Row wrap: step the destination row up or down
    if (end_row) begin
      row_d = DIM_W'(row_q + 1'b1);
      col_d = '0;
      if (DIM_W'(row_q + 1'b1) == h_dim) begin
        phase_d = PH_DONE;
      end else begin
        row_base_d = top_down_q ? row_base_q + IDX_W'(w_dim) : row_base_q - IDX_W'(w_dim);
        phase_d    = PH_PIXELS;
      end
    end
  end

  assign take_o = take;

  // Parse state, advanced once per consumed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      sig_ok_q   <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      depth_q    <= '0;
      start_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
      bip_q      <= '0;
      pad_q      <= '0;
      blue_q     <= '0;
      green_q    <= '0;
      row_base_q <= '0;
      top_down_q <= 1'b0;
    end else if (take) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      sig_ok_q   <= sig_ok_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_q    <= depth_d;
      start_q    <= start_d;
      row_q      <= row_d;
      col_q      <= col_d;
      bip_q      <= bip_d;
      pad_q      <= pad_d;
      blue_q     <= blue_d;
      green_q    <= green_d;
      row_base_q <= row_base_d;
      top_down_q <= top_down_d;
    end
  end

  // Derived header values follow the captured fields every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_h_q     <= '0;
      base_init_q <= '0;
    end else begin
      abs_h_q     <= abs_h_d;
      base_init_q <= base_init_d;
    end
  end

  // Padding is only entered with bytes left to drop
  a_pad_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAD |-> pad_q != 2'd0)
    else $error("pad phase with zero pad count");

  // The walk never runs past the last row
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS || phase_q == PH_PAD) |-> row_q < h_dim)
    else $error("row counter beyond image height");

  // Columns stay inside the row while pixels are read
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PIXELS |-> col_q < w_dim)
    else $error("column counter beyond image width");

  // The final pixel ends the image
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && res_valid_o && res_o.last_pixel) |=> phase_q == PH_DONE)
    else $error("parse continues after last pixel");

endmodule

// ===== design/bmp_out_reg.sv =====
// Result register of the BMP decoder: holds one pixel or error beat.
// Depends on bmp_pkg and bmp_pix_if.
module bmp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             res_valid_i,
  input  bmp_pkg::result_t res_i,
  output logic             can_take_o,
  bmp_pix_if.source        pix_o
);
  import bmp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign can_take_o = !valid_q || pix_o.ready;
  assign load       = take_i && res_valid_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pix_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign pix_o.valid        = valid_q;
  assign pix_o.kind         = res_q.kind;
  assign pix_o.red          = res_q.red;
  assign pix_o.green        = res_q.green;
  assign pix_o.blue         = res_q.blue;
  assign pix_o.pixel_index  = res_q.pixel_index;
  assign pix_o.image_width  = res_q.image_width;
  assign pix_o.image_height = res_q.image_height;
  assign pix_o.last_pixel   = res_q.last_pixel;

endmodule

// ===== design/bmp24_stream_decoder.sv =====
// Top level of the 24-bit BMP stream decoder.
// Depends on bmp_pkg, bmp_byte_if, bmp_pix_if, bmp_in_reg, bmp_parser, bmp_out_reg.
//
// Feed a BMP file one byte per beat on byte_i, with first_byte set on byte 0
// (after reset the first byte is taken as byte 0 even unmarked). The 54-byte
// header is checked on its last byte; a bad signature, a depth other than 24
// bits, or a width/height outside 1..4096 or data offset under 54 gives one
// error beat and the rest of the file is dropped. Otherwise each B,G,R triple
// comes out as one pixel beat with its top-row-first index; row padding and
// trailing bytes are dropped. The decoder takes one byte per clock while
// the result register is empty or being read: a byte is held in the input
// register, and when the parser takes it, it updates its counters and loads
// any result into the result register, which drives the output.
// No clearing pass is needed after reset.
module bmp24_stream_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmp_byte_if.sink  byte_i,
  bmp_pix_if.source pix_o
);
  import bmp_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     take;
  logic     can_take;
  logic     res_valid;
  result_t  res;

  bmp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bmp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .can_take_i   (can_take),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  bmp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_take_o  (can_take),
    .pix_o       (pix_o)
  );

endmodule

// ===== verif/tb.sv =====
// Testbench for bmp24_stream_decoder: feeds BMP files byte by byte and checks
// every pixel and error beat against an in-bench decoder model.
// Depends on bmp_pkg, bmp_byte_if, bmp_pix_if and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmp_pkg::*;

  localparam logic [15:0] SIG_OK      = {SIG_B, SIG_M};
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          RANDOM_BYTES = 150;
  localparam int          SHOW_ERRORS = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  bmp_byte_if byte_bus ();
  bmp_pix_if  pix_bus ();

  bmp24_stream_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_bus),
    .pix_o  (pix_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // No idling on either side while set
  bit steady = 1'b0;
  int cycle_count = 0;
  int beat_errors = 0;
  int parsed_bytes = 0;

  // Decoder model state
  phase_e           dec_phase;
  logic [31:0]      byte_pos;
  logic             sig_ok;
  logic [31:0]      width_raw;
  logic [31:0]      height_raw;
  logic [15:0]      depth_bits;
  logic [31:0]      data_ofs;
  logic [DIM_W-1:0] row_n;
  logic [DIM_W-1:0] col_n;
  logic [1:0]       byte_sel;
  logic [1:0]       pad_left;
  logic [7:0]       blue_hold;
  logic [7:0]       green_hold;
  logic [IDX_W-1:0] row_base_idx;
  logic             top_down;

  result_t expected_beats[$];

  function automatic void reset_decoder();
    dec_phase    = PH_HEADER;
    byte_pos     = '0;
    sig_ok       = 1'b0;
    width_raw    = '0;
    height_raw   = '0;
    depth_bits   = '0;
    data_ofs     = '0;
    row_n        = '0;
    col_n        = '0;
    byte_sel     = '0;
    pad_left     = '0;
    blue_hold    = '0;
    green_hold   = '0;
    row_base_idx = '0;
    top_down     = 1'b0;
  endfunction

  function automatic logic [31:0] abs_rows();
    return height_raw[31] ? (32'd0 - height_raw) : height_raw;
  endfunction

  // Destination index of column 0 of the current row
  function automatic void load_row_base();
    logic [31:0] dst;
    logic [31:0] prod;
    dst = top_down ? 32'(row_n) : abs_rows() - 32'd1 - 32'(row_n);
    prod = dst * width_raw;
    row_base_idx = prod[IDX_W-1:0];
  endfunction

  function automatic void grab_header_byte(input logic [31:0] p, input logic [7:0] b);
    if (p == OFS_SIG0) sig_ok = (b == SIG_B);
    else if (p == OFS_SIG1) sig_ok = sig_ok && (b == SIG_M);
    else if (p >= OFS_START && p < OFS_START + 4)
      data_ofs |= {24'd0, b} << (8 * (p - OFS_START));
    else if (p >= OFS_WIDTH && p < OFS_WIDTH + 4)
      width_raw |= {24'd0, b} << (8 * (p - OFS_WIDTH));
    else if (p >= OFS_HEIGHT && p < OFS_HEIGHT + 4)
      height_raw |= {24'd0, b} << (8 * (p - OFS_HEIGHT));
    else if (p >= OFS_DEPTH && p < OFS_DEPTH + 2)
      depth_bits |= {8'd0, b} << (8 * (p - OFS_DEPTH));
  endfunction

  function automatic void push_error(input kind_e k);
    result_t r;
    r = '0;
    r.kind = k;
    expected_beats.push_back(r);
    dec_phase = PH_DONE;
  endfunction

  // Header verdict on its last byte; first failing check wins
  function automatic void check_header();
    logic [31:0] h;
    h = abs_rows();
    if (!sig_ok) push_error(KIND_BAD_SIG);
    else if (depth_bits != DEPTH_RGB) push_error(KIND_BAD_DEPTH);
    else if (width_raw[31] || width_raw == 0 || width_raw > MAX_WIDTH ||
             h == 0 || h > MAX_HEIGHT || data_ofs < HDR_LEN) push_error(KIND_BAD_SIZE);
    else begin
      top_down = height_raw[31];
      row_n    = '0;
      col_n    = '0;
      byte_sel = '0;
      load_row_base();
      dec_phase = (data_ofs == HDR_LEN) ? PH_PIXELS : PH_SKIP;
    end
  endfunction

  function automatic void close_row();
    row_n++;
    col_n = '0;
    if (row_n >= abs_rows()) begin
      dec_phase = PH_DONE;
    end else begin
      load_row_base();
      dec_phase = PH_PIXELS;
    end
  endfunction

  // B, G, R bytes; the red byte completes the pixel
  function automatic void take_pixel_byte(input logic [7:0] b);
    result_t     r;
    logic        is_last;
    logic [31:0] h;
    h = abs_rows();
    case (byte_sel)
      2'd0: begin
        blue_hold = b;
        byte_sel  = 2'd1;
      end
      2'd1: begin
        green_hold = b;
        byte_sel   = 2'd2;
      end
      default: begin
        byte_sel = 2'd0;
        is_last = (row_n == h - 32'd1) && (col_n == width_raw - 32'd1);
        r.kind         = KIND_PIXEL;
        r.red          = b;
        r.green        = green_hold;
        r.blue         = blue_hold;
        r.pixel_index  = row_base_idx + col_n;
        r.image_width  = width_raw[OUT_DIM_W-1:0];
        r.image_height = h[OUT_DIM_W-1:0];
        r.last_pixel   = is_last;
        expected_beats.push_back(r);
        col_n++;
        if (col_n >= width_raw) begin
          pad_left = width_raw[1:0];
          if (pad_left != 0 && !is_last) dec_phase = PH_PAD;
          else close_row();
        end
      end
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic first);
    logic [31:0] p;
    if (first) reset_decoder();
    p = byte_pos;
    if (byte_pos != '1) byte_pos++;
    case (dec_phase)
      PH_HEADER: begin
        grab_header_byte(p, b);
        if (p == HDR_LEN - 1) check_header();
      end
      PH_SKIP: begin
        if (p >= data_ofs) begin
          dec_phase = PH_PIXELS;
          take_pixel_byte(b);
        end
      end
      PH_PIXELS: take_pixel_byte(b);
      PH_PAD: begin
        if (pad_left != 0) pad_left--;
        if (pad_left == 0) close_row();
      end
      default: ;
    endcase
  endfunction

  // One byte beat; entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic first);
    while (!steady && $urandom_range(99) < 27) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.data_byte  <= b;
    byte_bus.first_byte <= first;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    if (first || dec_phase != PH_DONE) parsed_bytes++;
    decode_byte(b, first);
    @(negedge clk_i);
  endtask

  // Builds a file with random filler and pixel bytes; cut >= 0 stops early
  task automatic send_file(input logic [15:0] sig, input logic [31:0] ofs,
                           input logic [31:0] w, input logic [31:0] h,
                           input logic [15:0] bpp, input int trail,
                           input bit mark, input int cut);
    logic [7:0]  img[$];
    logic [31:0] rows;
    logic [31:0] area;
    int          n_bytes;
    for (int i = 0; i < HDR_LEN; i++) img.push_back(8'($urandom_range(255)));
    img[OFS_SIG0] = sig[15:8];
    img[OFS_SIG1] = sig[7:0];
    for (int k = 0; k < 4; k++) begin
      img[OFS_START + k]  = ofs[8*k +: 8];
      img[OFS_WIDTH + k]  = w[8*k +: 8];
      img[OFS_HEIGHT + k] = h[8*k +: 8];
    end
    img[OFS_DEPTH]     = bpp[7:0];
    img[OFS_DEPTH + 1] = bpp[15:8];
    rows = h[31] ? (32'd0 - h) : h;
    // Gap and padded rows, only where sizes are sane and the gap is short
    if (!w[31] && w != 0 && w <= MAX_WIDTH && rows != 0 && rows <= MAX_HEIGHT &&
        ofs >= HDR_LEN && ofs - HDR_LEN <= 64) begin
      area = (ofs - HDR_LEN) + rows * (3 * w + 32'(w[1:0]));
      for (int i = 0; i < area && (cut < 0 || img.size() < cut); i++)
        img.push_back(8'($urandom_range(255)));
    end
    repeat (trail) img.push_back(8'($urandom_range(255)));
    n_bytes = (cut >= 0 && cut < img.size()) ? cut : img.size();
    for (int i = 0; i < n_bytes; i++) send_byte(img[i], mark && i == 0);
  endtask

  function automatic string beat_text(input result_t r);
    return $sformatf("kind=%0d rgb=%02x%02x%02x idx=%0d w=%0d h=%0d last=%0b",
                     r.kind, r.red, r.green, r.blue, r.pixel_index, r.image_width,
                     r.image_height, r.last_pixel);
  endfunction

  function automatic void report(input string what, input result_t want, input result_t got);
    beat_errors++;
    if (beat_errors <= SHOW_ERRORS)
      $display("%0t %s: exp %s | got %s", $realtime, what, beat_text(want), beat_text(got));
  endfunction

  // Result checker: every accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && pix_bus.valid && pix_bus.ready) begin
      got.kind         = kind_e'(pix_bus.kind);
      got.red          = pix_bus.red;
      got.green        = pix_bus.green;
      got.blue         = pix_bus.blue;
      got.pixel_index  = pix_bus.pixel_index;
      got.image_width  = pix_bus.image_width;
      got.image_height = pix_bus.image_height;
      got.last_pixel   = pix_bus.last_pixel;
      if (expected_beats.size() == 0) begin
        report("unexpected beat", '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.pixel_index !== want.pixel_index ||
            got.image_width !== want.image_width || got.image_height !== want.image_height ||
            got.last_pixel !== want.last_pixel)
          report("mismatch", want, got);
      end
    end
  end

  // Receiver throttle
  always @(negedge clk_i) pix_bus.ready <= steady || ($urandom_range(99) >= 27);

  always @(posedge clk_i) cycle_count++;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // Right after reset the decoder parses without a start mark
  task automatic test_unmarked_start();
    send_file(SIG_OK, 32'd54, 32'd2, 32'd2, 16'd24, 2, 1'b0, -1);
  endtask

  // Signature, depth and size checks, including their priority
  task automatic test_header_checks();
    send_file({8'h41, SIG_M}, 32'd54, 32'd2, 32'd2, 16'd24, 3, 1'b1, -1);
    send_file({SIG_B, 8'h4E}, 32'd54, 32'd2, 32'd2, 16'd32, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd0, 32'd2, 16'd32, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd2, 32'd2, 16'h0118, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd0, 32'd2, 16'd24, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'hFFFF_FFFF, 32'd2, 16'd24, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd4097, 32'd2, 16'd24, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd2, 32'd0, 16'd24, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd2, 32'd4097, 16'd24, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd2, 32'hFFFF_EFFF, 16'd24, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd2, 32'h8000_0000, 16'd24, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd53, 32'd2, 32'd2, 16'd24, 3, 1'b1, -1);
    send_file(SIG_OK, 32'd0, 32'd2, 32'd2, 16'd24, 3, 1'b1, -1);
  endtask

  // Bottom-up and top-down rows, data gaps, padding and trailing bytes
  task automatic test_row_order();
    send_file(SIG_OK, 32'd54, 32'd3, 32'd3, 16'd24, 0, 1'b1, -1);
    send_file(SIG_OK, 32'd57, 32'd3, 32'hFFFF_FFFD, 16'd24, 4, 1'b1, -1);
    send_file(SIG_OK, 32'd55, 32'd2, 32'd2, 16'd24, 6, 1'b1, -1);
    send_file(SIG_OK, 32'd54, 32'd1, 32'd1, 16'd24, 5, 1'b1, -1);
  endtask

  // Largest width and height, each file cut after its first pixels;
  // the tall one runs with no idling at all
  task automatic test_size_extremes();
    send_file(SIG_OK, 32'd54, 32'd4096, 32'd4096, 16'd24, 0, 1'b1, 90);
    steady = 1'b1;
    send_file(SIG_OK, 32'd54, 32'd1, 32'hFFFF_F000, 16'd24, 0, 1'b1, 174);
    steady = 1'b0;
    send_file(SIG_OK, 32'd56, 32'd4095, 32'd2, 16'd24, 0, 1'b1, 80);
  endtask

  // Restart in the header, mid-pixel, in padding, and while skipping a huge gap
  task automatic test_restart();
    send_file(SIG_OK, 32'd54, 32'd3, 32'd2, 16'd24, 0, 1'b1, 20);
    send_file(SIG_OK, 32'd54, 32'd3, 32'd2, 16'd24, 0, 1'b1, 59);
    send_file(SIG_OK, 32'd54, 32'd3, 32'd2, 16'd24, 0, 1'b1, 64);
    send_file(SIG_OK, 32'hFFFF_FFF0, 32'd2, 32'd2, 16'd24, 30, 1'b1, -1);
    send_file(SIG_OK, 32'd56, 32'd3, 32'hFFFF_FFFE, 16'd24, 7, 1'b1, -1);
  endtask

  // Sender holds off until the result side has drained
  task automatic test_drain_pause();
    send_file(SIG_OK, 32'd54, 32'd5, 32'hFFFF_FFFE, 16'd24, 1, 1'b1, -1);
    byte_bus.valid <= 1'b0;
    do @(negedge clk_i); while (expected_beats.size() != 0);
    send_file(SIG_OK, 32'd54, 32'd6, 32'd2, 16'd24, 1, 1'b1, -1);
  endtask

  // Mostly well-formed small images, some broken headers, cut files and noise
  task automatic test_random_files();
    int          start;
    int          pick;
    int          rows;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] ofs;
    logic [15:0] sig;
    logic [15:0] bpp;
    start = parsed_bytes;
    while (parsed_bytes - start < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      w    = $urandom_range(1, 9);
      rows = $urandom_range(1, 5);
      h    = $urandom_range(1) ? (32'd0 - rows) : rows;
      ofs  = HDR_LEN + (($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
      sig  = SIG_OK;
      bpp  = DEPTH_RGB;
      if (pick < 70) begin
        send_file(sig, ofs, w, h, bpp, $urandom_range(4), $urandom_range(19) != 0, -1);
      end else if (pick < 80) begin
        // corrupt one header field
        case ($urandom_range(4))
          0: sig = 16'($urandom);
          1: bpp = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 40));
          2: w   = $urandom_range(1) ? $urandom : 32'd0;
          3: h   = $urandom;
          default: ofs = $urandom_range(0, 60);
        endcase
        send_file(sig, ofs, w, h, bpp, $urandom_range(4), 1'b1, -1);
      end else if (pick < 90) begin
        send_file(sig, ofs, w, h, bpp, 0, 1'b1, $urandom_range(1, 100));
      end else begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
    end
  endtask

  initial begin
    reset_decoder();
    rst_ni              = 1'b0;
    byte_bus.valid      = 1'b0;
    byte_bus.data_byte  = '0;
    byte_bus.first_byte = 1'b0;
    pix_bus.ready       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_unmarked_start();
    test_header_checks();
    test_row_order();
    test_size_extremes();
    test_restart();
    test_drain_pause();
    test_random_files();

    byte_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (beat_errors == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d bad beats, %0d results missing", beat_errors, expected_beats.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bmp_pkg.sv
design/bmp_byte_if.sv
design/bmp_pix_if.sv
design/bmp_in_reg.sv
design/bmp_parser.sv
design/bmp_out_reg.sv
design/bmp24_stream_decoder.sv
verif/tb.sv
